>>> hdl/assert_macros.svh
// Assertion helpers used by the checker file pbal_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define PBAL_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the standard i_clk / i_rst_n pair.
`define PBAL_ASSERT(label, prop, msg) \
    `PBAL_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

>>> hdl/pbal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbal_pkg;

    localparam int HDR_W  = 7;
    localparam int REQ_W  = 17;
    localparam int ADDR_W = 16;
    localparam int TAG_W  = 5;

    localparam logic [HDR_W-1:0] HDR_RESET = 7'd12;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STAT_ALLOC = 2'd0;
    localparam logic [1:0] STAT_NOBLK = 2'd1;
    localparam logic [1:0] STAT_OVER  = 2'd2;
    localparam logic [1:0] STAT_FREED = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] user_address;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] result_address;
        logic [REQ_W-1:0]  freed_bytes;
    } t_out_word;

endpackage

`default_nettype wire

>>> hdl/pbal_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pbal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/pbal_heads.sv
`timescale 1ns / 1ps
`default_nettype none

module pbal_heads #(
    parameter int POOL_ORDER = 16,
    parameter int MIN_ORDER  = 4
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_we,
    input  wire logic [$clog2(POOL_ORDER-MIN_ORDER+1)-1:0]    i_waddr,
    input  wire logic [POOL_ORDER-MIN_ORDER:0]                i_wdata,
    input  wire logic [$clog2(POOL_ORDER-MIN_ORDER+1)-1:0]    i_raddr,
    output logic      [POOL_ORDER-MIN_ORDER:0]                o_rdata,
    input  wire logic [$clog2(POOL_ORDER-MIN_ORDER+1)-1:0]    i_base,
    output logic                                              o_found,
    output logic      [$clog2(POOL_ORDER-MIN_ORDER+1)-1:0]    o_found_ord
);

    localparam int IW   = POOL_ORDER - MIN_ORDER;
    localparam int HW   = IW + 1;
    localparam int NORD = IW + 1;
    localparam int OW   = $clog2(NORD);

    localparam logic [HW-1:0] EMPTY_MARK = {1'b1, {IW{1'b0}}};

    logic [HW-1:0] r_heads [NORD];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NORD; i++) begin
                r_heads[i] <= (i == NORD - 1) ? '0 : EMPTY_MARK;
            end
        end else if (i_we) begin
            r_heads[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_heads[i_raddr];

    // lowest nonempty order at or above the base order
    always_comb begin
        o_found     = 1'b0;
        o_found_ord = '0;
        for (int i = NORD - 1; i >= 0; i--) begin
            if (OW'(i) >= i_base && !r_heads[i][HW-1]) begin
                o_found     = 1'b1;
                o_found_ord = OW'(i);
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/power_of_two_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Power-of-two block allocator over a 2^POOL_ORDER byte pool, no coalescing.
// Input channel: i_in_valid / o_in_stall carry one word: an allocate with a
// byte count or a free with a user address. Output channel: o_out_valid /
// i_out_stall carry one result word for every input word, in order.
// Configuration: i_cfg_we writes header_bytes from i_cfg_wdata; write it only
// while the block is idle. Reset value of header_bytes is 12.
// One word is processed at a time; o_in_stall stays high from acceptance
// until the result is loaded into the output register.
// Allocate: SIZE, ORD, FIND, HEAD and POP, then one SPLIT step per split
// (0 to POOL_ORDER - MIN_ORDER splits), one free-list link write per split
// through the single write port of the link/tag memory. A failed allocate
// ends after ORD (oversized) or FIND (no block). Free: address, tag read, push.
// Every word ends in DONE, which loads its result into the output register.
// The output register holds a finished result while the receiver stalls; the
// next word is still accepted and is worked up to its result load.
// Reset: the whole pool is one free block of the top order, the output
// register is empty and the block is ready at once; no memory sweep is run.

module power_of_two_block_allocator #(
    parameter int POOL_ORDER = 16,
    parameter int MIN_ORDER  = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire pbal_pkg::t_in_word            i_in_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output pbal_pkg::t_out_word                o_out_word,
    input  wire logic                          i_cfg_we,
    input  wire logic [pbal_pkg::HDR_W-1:0]    i_cfg_wdata
);

    localparam int IW    = POOL_ORDER - MIN_ORDER;
    localparam int HW    = IW + 1;
    localparam int NORD  = IW + 1;
    localparam int OW    = $clog2(NORD);
    localparam int TW    = pbal_pkg::TAG_W;
    localparam int RW    = HW + TW;
    localparam int NW    = pbal_pkg::REQ_W + 1;
    localparam int CW    = (POOL_ORDER + 1 > NW) ? POOL_ORDER + 1 : NW;

    localparam logic [HW-1:0] EMPTY_MARK = {1'b1, {IW{1'b0}}};
    localparam logic [TW-1:0] TAG_MIN    = TW'(MIN_ORDER);
    localparam logic [TW-1:0] TAG_MAX    = TW'(POOL_ORDER);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SIZE  = 4'd1;
    localparam logic [3:0] ST_ORD   = 4'd2;
    localparam logic [3:0] ST_FIND  = 4'd3;
    localparam logic [3:0] ST_HEAD  = 4'd4;
    localparam logic [3:0] ST_POP   = 4'd5;
    localparam logic [3:0] ST_SPLIT = 4'd6;
    localparam logic [3:0] ST_FADDR = 4'd7;
    localparam logic [3:0] ST_FREAD = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0]                   r_state, n_state;
    logic [pbal_pkg::HDR_W-1:0]   r_hdr;
    logic [pbal_pkg::REQ_W-1:0]   r_req;
    logic [pbal_pkg::ADDR_W-1:0]  r_ua;
    logic [NW-1:0]                r_need;
    logic [OW-1:0]                r_k;
    logic [OW-1:0]                r_j;
    logic [OW-1:0]                r_o;
    logic [IW-1:0]                r_idx;
    logic                         r_init0;
    pbal_pkg::t_out_word          r_res;
    logic                         r_out_valid;
    pbal_pkg::t_out_word          r_out_word;

    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0] ram_wdata, ram_q;

    logic          hd_we;
    logic [OW-1:0] hd_waddr, hd_raddr;
    logic [HW-1:0] hd_wdata, hd_rdata;
    logic          hd_found;
    logic [OW-1:0] hd_found_ord;

    logic [CW-1:0] free_diff;
    logic [IW-1:0] free_idx;
    logic          over;
    logic [OW-1:0] k_calc;
    logic [HW-1:0] link_q;
    logic [TW-1:0] tag_q;
    logic [TW-1:0] ord_c;
    logic [OW-1:0] ord_idx;
    logic [OW-1:0] split_ord;
    logic [IW-1:0] upper_idx;
    logic [CW-1:0] blk_size;
    logic [CW-1:0] freed_w;
    logic [CW-1:0] addr_w;
    logic          out_free;

    pbal_ram #(
        .WIDTH (RW),
        .DEPTH (1 << IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    pbal_heads #(
        .POOL_ORDER (POOL_ORDER),
        .MIN_ORDER  (MIN_ORDER)
    ) u_heads (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_we        (hd_we),
        .i_waddr     (hd_waddr),
        .i_wdata     (hd_wdata),
        .i_raddr     (hd_raddr),
        .o_rdata     (hd_rdata),
        .i_base      (r_k),
        .o_found     (hd_found),
        .o_found_ord (hd_found_ord)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign out_free    = !r_out_valid || !i_out_stall;

    // size class and range check
    assign over = CW'(r_need) > (CW'(1) << POOL_ORDER);
    always_comb begin
        k_calc = OW'(NORD - 1);
        for (int i = NORD - 2; i >= 0; i--) begin
            if (CW'(r_need) <= (CW'(1) << (MIN_ORDER + i))) begin
                k_calc = OW'(i);
            end
        end
    end

    assign free_diff = CW'(r_ua) - CW'(r_hdr);
    assign free_idx  = IW'(free_diff >> MIN_ORDER);

    // block zero reads as the whole pool until its entry is first written
    assign link_q = (r_init0 && r_idx == '0) ? EMPTY_MARK : ram_q[TW +: HW];
    assign tag_q  = (r_init0 && r_idx == '0) ? TAG_MAX : ram_q[TW-1:0];

    always_comb begin
        ord_c = tag_q;
        if (tag_q < TAG_MIN) begin
            ord_c = TAG_MIN;
        end else if (tag_q > TAG_MAX) begin
            ord_c = TAG_MAX;
        end
    end
    assign ord_idx = OW'(ord_c - TAG_MIN);

    assign split_ord = r_o - OW'(1);
    assign upper_idx = r_idx + (IW'(1) << split_ord);

    assign blk_size = CW'(1) << ord_c;
    assign freed_w  = (blk_size > CW'(r_hdr)) ? blk_size - CW'(r_hdr) : '0;
    assign addr_w   = (CW'(r_idx) << MIN_ORDER) + CW'(r_hdr);

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = {link_q, TW'(r_k) + TAG_MIN};
        ram_re    = 1'b0;
        ram_raddr = hd_rdata[IW-1:0];
        hd_we     = 1'b0;
        hd_waddr  = r_j;
        hd_wdata  = link_q;
        hd_raddr  = r_j;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_word.opcode == pbal_pkg::OP_FREE) ? ST_FADDR : ST_SIZE;
                end
            end
            ST_SIZE: begin
                n_state = ST_ORD;
            end
            ST_ORD: begin
                n_state = over ? ST_DONE : ST_FIND;
            end
            ST_FIND: begin
                n_state = hd_found ? ST_HEAD : ST_DONE;
            end
            ST_HEAD: begin
                ram_re  = 1'b1;
                n_state = ST_POP;
            end
            ST_POP: begin
                ram_we  = 1'b1;
                hd_we   = 1'b1;
                n_state = (r_j != r_k) ? ST_SPLIT : ST_DONE;
            end
            ST_SPLIT: begin
                hd_raddr  = split_ord;
                ram_we    = 1'b1;
                ram_waddr = upper_idx;
                ram_wdata = {hd_rdata, TW'(split_ord) + TAG_MIN};
                hd_we     = 1'b1;
                hd_waddr  = split_ord;
                hd_wdata  = {1'b0, upper_idx};
                n_state   = (split_ord == r_k) ? ST_DONE : ST_SPLIT;
            end
            ST_FADDR: begin
                ram_re    = 1'b1;
                ram_raddr = free_idx;
                n_state   = ST_FREAD;
            end
            ST_FREAD: begin
                hd_raddr  = ord_idx;
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = {hd_rdata, ord_c};
                hd_we     = 1'b1;
                hd_waddr  = ord_idx;
                hd_wdata  = {1'b0, r_idx};
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hdr       <= pbal_pkg::HDR_RESET;
            r_init0     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_hdr <= i_cfg_wdata;
            end
            if (ram_we && ram_waddr == '0) begin
                r_init0 <= 1'b0;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_req <= i_in_word.request_bytes;
                r_ua  <= i_in_word.user_address;
            end
            ST_SIZE: begin
                r_need <= NW'(r_req) + NW'(r_hdr);
            end
            ST_ORD: begin
                r_k   <= k_calc;
                r_res <= '{status: pbal_pkg::STAT_OVER, result_address: '0, freed_bytes: '0};
            end
            ST_FIND: begin
                r_j   <= hd_found_ord;
                r_res <= '{status: pbal_pkg::STAT_NOBLK, result_address: '0, freed_bytes: '0};
            end
            ST_HEAD: begin
                r_idx <= hd_rdata[IW-1:0];
            end
            ST_POP: begin
                r_o   <= r_j;
                r_res <= '{status: pbal_pkg::STAT_ALLOC,
                           result_address: pbal_pkg::ADDR_W'(addr_w),
                           freed_bytes: '0};
            end
            ST_SPLIT: begin
                r_o <= split_ord;
            end
            ST_FADDR: begin
                r_idx <= free_idx;
            end
            ST_FREAD: begin
                r_res <= '{status: pbal_pkg::STAT_FREED,
                           result_address: '0,
                           freed_bytes: pbal_pkg::REQ_W'(freed_w)};
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_word <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/pbal_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pbal_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire pbal_pkg::t_out_word o_out_word
);

    `PBAL_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word), "stalled output word changed")

    `PBAL_ASSERT(a_one_at_a_time, i_rst_n && i_in_valid && !o_in_stall |=> o_in_stall, "second word accepted while busy")

    `PBAL_ASSERT(a_addr_only_alloc, o_out_valid && o_out_word.status != pbal_pkg::STAT_ALLOC |-> o_out_word.result_address == '0, "address on non-allocate result")

    `PBAL_ASSERT(a_freed_only_free, o_out_valid && o_out_word.status != pbal_pkg::STAT_FREED |-> o_out_word.freed_bytes == '0, "freed size on non-free result")

endmodule

bind power_of_two_block_allocator pbal_checker u_pbal_checker (.*);

`default_nettype wire

>>> sim/power_of_two_block_allocator_checker.sv
`timescale 1ns / 1ps

module power_of_two_block_allocator_checker
    import pbal_pkg::*;
#(
    parameter int POOL_ORDER = 16,
    parameter int MIN_ORDER  = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_word   i_in_word,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_word  i_out_word,
    input  logic       i_cfg_we,
    input  logic [HDR_W-1:0] i_cfg_wdata,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int BLOCKS = 1 << (POOL_ORDER - MIN_ORDER);
    localparam int ORDERS = POOL_ORDER - MIN_ORDER + 1;
    localparam int IDX_W  = POOL_ORDER - MIN_ORDER + 1;
    localparam logic [IDX_W-1:0] NO_BLOCK = IDX_W'(BLOCKS);

    logic [IDX_W-1:0] free_heads [ORDERS];
    logic [IDX_W-1:0] chain_next [BLOCKS];
    logic [TAG_W-1:0] size_tags  [BLOCKS];
    logic [HDR_W-1:0] cur_header;
    t_out_word        awaited_results [$];
    int               fail_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void file_block(input int idx, input int ord);
        idx = idx & (BLOCKS - 1);
        size_tags[idx]               = TAG_W'(ord);
        chain_next[idx]              = free_heads[ord - MIN_ORDER];
        free_heads[ord - MIN_ORDER]  = IDX_W'(idx);
    endfunction

    function automatic t_out_word serve_request(input t_in_word w);
        t_out_word r;
        int need;
        int k;
        int j;
        int idx;
        int ord;
        int base;
        int size;
        r = '0;
        if (w.opcode == OP_ALLOC) begin
            need = int'(w.request_bytes) + int'(cur_header);
            if (need > (1 << POOL_ORDER)) begin
                r.status = STAT_OVER;
                return r;
            end
            k = MIN_ORDER;
            while (k < POOL_ORDER && (1 << k) < need) k++;
            j = k;
            while (j <= POOL_ORDER && free_heads[j - MIN_ORDER] == NO_BLOCK) j++;
            if (j > POOL_ORDER) begin
                r.status = STAT_NOBLK;
                return r;
            end
            idx = int'(free_heads[j - MIN_ORDER]) & (BLOCKS - 1);
            free_heads[j - MIN_ORDER] = chain_next[idx];
            for (int o = j; o > k; o--)
                file_block(idx + (1 << (o - 1 - MIN_ORDER)), o - 1);
            size_tags[idx]   = TAG_W'(k);
            r.status         = STAT_ALLOC;
            r.result_address = ADDR_W'((idx << MIN_ORDER) + int'(cur_header));
        end else begin
            base = (int'(w.user_address) - int'(cur_header)) & ((1 << POOL_ORDER) - 1);
            idx  = (base >> MIN_ORDER) & (BLOCKS - 1);
            ord  = int'(size_tags[idx]);
            if (ord < MIN_ORDER) ord = MIN_ORDER;
            if (ord > POOL_ORDER) ord = POOL_ORDER;
            file_block(idx, ord);
            size     = 1 << ord;
            r.status = STAT_FREED;
            if (size > int'(cur_header))
                r.freed_bytes = REQ_W'(size - int'(cur_header));
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word want;
        if (!i_rst_n) begin
            cur_header = HDR_RESET;
            for (int o = 0; o < ORDERS; o++) free_heads[o] = NO_BLOCK;
            for (int b = 0; b < BLOCKS; b++) begin
                chain_next[b] = '0;
                size_tags[b]  = '0;
            end
            chain_next[0]          = NO_BLOCK;
            size_tags[0]           = TAG_W'(POOL_ORDER);
            free_heads[ORDERS - 1] = '0;
            awaited_results.delete();
        end else begin
            if (i_cfg_we)
                cur_header = i_cfg_wdata;
            // compare first: a word accepted now cannot answer at the same edge
            if (i_out_valid && !i_out_stall) begin
                got = i_out_word;
                if (awaited_results.size() == 0) begin
                    $error("result word with none outstanding: status %0d", got.status);
                    fail_total++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_total++;
                    end
                    if (got.result_address !== want.result_address) begin
                        $error("result_address: expected %0d, got %0d",
                               want.result_address, got.result_address);
                        fail_total++;
                    end
                    if (got.freed_bytes !== want.freed_bytes) begin
                        $error("freed_bytes: expected %0d, got %0d",
                               want.freed_bytes, got.freed_bytes);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(serve_request(i_in_word));
        end
        o_fail_count <= fail_total;
        o_pending    <= awaited_results.size();
    end

endmodule

>>> sim/power_of_two_block_allocator_test.sv
`timescale 1ns / 1ps

module power_of_two_block_allocator_test;
    import pbal_pkg::*;

    localparam int HOLD_CYCLES = 200;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_in_word         in_word   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_word        out_word;
    logic             cfg_we    = 1'b0;
    logic [HDR_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;

    int               idle_pct      = 21;
    int               stall_pct     = 21;
    logic             long_hold     = 1'b0;
    logic             collect_bases = 1'b0;
    int               cur_hdr       = int'(HDR_RESET);
    int               words_sent    = 0;
    int               status_seen [4] = '{0, 0, 0, 0};
    logic [ADDR_W-1:0] live_bases [$];

    always #4 clk = ~clk;

    power_of_two_block_allocator DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    power_of_two_block_allocator_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver: random stall, or one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (long_hold) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (!$isunknown(out_word.status))
                status_seen[out_word.status]++;
            if (collect_bases && out_word.status == STAT_ALLOC)
                live_bases.push_back(out_word.result_address - ADDR_W'(cur_hdr));
        end
    end

    function automatic t_in_word alloc_word(input int bytes);
        t_in_word w;
        w.opcode        = OP_ALLOC;
        w.request_bytes = REQ_W'(bytes);
        w.user_address  = ADDR_W'($urandom_range(65535));
        return w;
    endfunction

    function automatic t_in_word free_word(input int addr);
        t_in_word w;
        w.opcode        = OP_FREE;
        w.request_bytes = REQ_W'($urandom_range(65536));
        w.user_address  = ADDR_W'(addr);
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_header(input int value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= HDR_W'(value);
        cur_hdr    = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int refree_pct);
        int       pick;
        int       r;
        int       bytes;
        t_in_word w;
        logic [ADDR_W-1:0] base;
        for (int n = 0; n < count; n++) begin
            if (live_bases.size() == 0 ||
                $urandom_range(99) < ((n < count / 2) ? 75 : 40)) begin
                r = $urandom_range(99);
                if (r < 70)
                    bytes = $urandom_range(200);
                else if (r < 90)
                    bytes = $urandom_range(4096);
                else if (r < 97)
                    bytes = $urandom_range(65536);
                else
                    bytes = (1 << 16) - cur_hdr + $urandom_range(1);
                if (bytes > 65536)
                    bytes = 65536;
                w = alloc_word(bytes);
            end else begin
                pick = $urandom_range(live_bases.size() - 1);
                base = live_bases[pick];
                // keep the entry now and then so the same block is released twice
                if ($urandom_range(99) >= refree_pct)
                    live_bases.delete(pick);
                w = free_word(int'(base) + cur_hdr + $urandom_range(15));
            end
            send_word(w);
        end
    endtask

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int last_hdr;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(alloc_word(65524));
        send_word(alloc_word(0));
        send_word(alloc_word(65536));
        send_word(alloc_word(65525));
        send_word(free_word(12));
        send_word(alloc_word(0));
        send_word(alloc_word(4));
        send_word(alloc_word(5));
        send_word(free_word(35));
        send_word(alloc_word(4));
        send_word(alloc_word(32756));
        send_word(alloc_word(32757));
        send_word(free_word(12));
        send_word(free_word(16'h801B));
        send_word(alloc_word(65524));

        // hold the sender until every result is back
        drain();
        collect_bases = 1'b1;

        idle_pct  = 0;
        stall_pct = 0;
        write_header(0);
        run_phase(250, 0);

        idle_pct  = 21;
        stall_pct = 21;
        write_header(64);
        long_hold <= 1'b1;
        run_phase(250, 0);

        write_header(63);
        run_phase(250, 0);

        last_hdr = $urandom_range(64);
        write_header(last_hdr);
        run_phase(250, 6);

        drain();
        $display("Covered %0d words: %0d allocations, %0d with no free block, %0d oversized, %0d frees",
                 words_sent, status_seen[STAT_ALLOC], status_seen[STAT_NOBLK],
                 status_seen[STAT_OVER], status_seen[STAT_FREED]);
        $display("Header settings 12, 0, 64, 63, %0d; one long output hold-off; repeated frees at the end",
                 last_hdr);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/pbal_pkg.sv
hdl/pbal_ram.sv
hdl/pbal_heads.sv
hdl/power_of_two_block_allocator.sv
hdl/pbal_checker.sv
sim/power_of_two_block_allocator_checker.sv
sim/power_of_two_block_allocator_test.sv
